FILE: rtl/shpe_pkg.sv
// ----------------------------------------------------------------------------
// shpe_pkg
// shared types, constants and tables for the polar harmonic evaluator
// ----------------------------------------------------------------------------
package shpe_pkg;

	// pipeline depth from input register to output register
	localparam int LAT      = 21;

	localparam logic [31:0] PI30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI30 = 32'd1686629713;
	localparam logic [63:0] IPI48     = 64'd89596267800354;

	localparam int VAL_W  = 18;
	localparam int TRIG_W = 26;
	localparam int TERM_W = 36;
	localparam int POLY_W = 39;
	localparam int T_W    = 40;
	localparam int K_W    = 25;

	localparam logic [VAL_W-1:0] VAL_MAX = 18'h1FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 18'h20000;

	typedef struct packed {
		logic [3:0] row;
		logic       zero;
		logic       bad;
		logic       neg;
	} ctl_t;

	// taylor divisors: sine steps then cosine steps
	localparam int unsigned DIVS [14] = '{
		210, 156, 110, 72, 42, 20, 6,
		182, 132, 90, 56, 30, 12, 2
	};

	localparam logic [31:0] RCP [14] = '{
		32'(64'd4294967296 / 64'd210), 32'(64'd4294967296 / 64'd156),
		32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
		32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
		32'(64'd4294967296 / 64'd6),
		32'(64'd4294967296 / 64'd182), 32'(64'd4294967296 / 64'd132),
		32'(64'd4294967296 / 64'd90),  32'(64'd4294967296 / 64'd56),
		32'(64'd4294967296 / 64'd30),  32'(64'd4294967296 / 64'd12),
		32'(64'd4294967296 / 64'd2)
	};

	// legendre coefficients by row, ascending powers of cos
	localparam logic signed [9:0] POLY [16][7] = '{
		'{ 10'sd1,   10'sd0, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{-10'sd1,   10'sd0, 10'sd3,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd0,   10'sd1, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd1,   10'sd0, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd3,   10'sd0, -10'sd30,  10'sd0,   10'sd35,   10'sd0,  10'sd0},
		'{ 10'sd0,  -10'sd3, 10'sd0,    10'sd7,   10'sd0,    10'sd0,  10'sd0},
		'{-10'sd1,   10'sd0, 10'sd7,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd0,   10'sd1, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd1,   10'sd0, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{-10'sd5,   10'sd0, 10'sd105,  10'sd0,   -10'sd315, 10'sd0,  10'sd231},
		'{ 10'sd0,   10'sd5, 10'sd0,    -10'sd30, 10'sd0,    10'sd33, 10'sd0},
		'{ 10'sd1,   10'sd0, -10'sd18,  10'sd0,   10'sd33,   10'sd0,  10'sd0},
		'{ 10'sd0,  -10'sd3, 10'sd0,    10'sd11,  10'sd0,    10'sd0,  10'sd0},
		'{-10'sd1,   10'sd0, 10'sd11,   10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd0,   10'sd1, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0},
		'{ 10'sd1,   10'sd0, 10'sd0,    10'sd0,   10'sd0,    10'sd0,  10'sd0}
	};

	// power of sin per row
	localparam logic [2:0] P_EXP [16] = '{
		3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd3,
		3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
	};

	// shift right with rounding, half away from zero on a magnitude
	function automatic logic [63:0] rnd_sh(input logic [63:0] p, input int unsigned sh);
		return (p + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// signed q24 product, rounded on the magnitude
	function automatic logic signed [TRIG_W-1:0] mul24(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic [TRIG_W-1:0] am;
		logic [TRIG_W-1:0] bm;
		logic [TRIG_W-1:0] m;
		am = a[TRIG_W-1] ? TRIG_W'(-a) : TRIG_W'(a);
		bm = b[TRIG_W-1] ? TRIG_W'(-b) : TRIG_W'(b);
		m  = TRIG_W'(rnd_sh(64'(am) * 64'(bm), 24));
		return (a[TRIG_W-1] != b[TRIG_W-1]) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res  = 64'd0;
		rem  = v;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// normalising factor per row, q24
	function automatic logic [K_W-1:0] k_of(input int unsigned r);
		logic [K_W-1:0] k;
		case (r)
			0: k = K_W'((64'd1 * isqrt64((64'd1 * IPI48) / 64'd1) + 64'd1) / 64'd2);
			1: k = K_W'((64'd1 * isqrt64((64'd5 * IPI48) / 64'd1) + 64'd2) / 64'd4);
			2: k = K_W'((64'd1 * isqrt64((64'd15 * IPI48 + 64'd1) / 64'd2) + 64'd1) / 64'd2);
			3: k = K_W'((64'd1 * isqrt64((64'd15 * IPI48 + 64'd1) / 64'd2) + 64'd2) / 64'd4);
			4: k = K_W'((64'd3 * isqrt64((64'd1 * IPI48) / 64'd1) + 64'd8) / 64'd16);
			5: k = K_W'((64'd3 * isqrt64((64'd5 * IPI48) / 64'd1) + 64'd4) / 64'd8);
			6: k = K_W'((64'd3 * isqrt64((64'd5 * IPI48 + 64'd1) / 64'd2) + 64'd4) / 64'd8);
			7: k = K_W'((64'd3 * isqrt64((64'd35 * IPI48) / 64'd1) + 64'd4) / 64'd8);
			8: k = K_W'((64'd3 * isqrt64((64'd35 * IPI48 + 64'd1) / 64'd2) + 64'd8) / 64'd16);
			9: k = K_W'((64'd1 * isqrt64((64'd13 * IPI48) / 64'd1) + 64'd16) / 64'd32);
			10: k = K_W'((64'd1 * isqrt64((64'd273 * IPI48 + 64'd1) / 64'd2) + 64'd8)
				/ 64'd16);
			11: k = K_W'((64'd1 * isqrt64((64'd1365 * IPI48) / 64'd1) + 64'd32) / 64'd64);
			12: k = K_W'((64'd1 * isqrt64((64'd1365 * IPI48) / 64'd1) + 64'd16) / 64'd32);
			13: k = K_W'((64'd3 * isqrt64((64'd91 * IPI48 + 64'd1) / 64'd2) + 64'd16)
				/ 64'd32);
			14: k = K_W'((64'd3 * isqrt64((64'd1001 * IPI48) / 64'd1) + 64'd16) / 64'd32);
			15: k = K_W'((64'd1 * isqrt64((64'd3003 * IPI48) / 64'd1) + 64'd32) / 64'd64);
			default: k = '0;
		endcase
		return k;
	endfunction

	localparam logic [K_W-1:0] K_TAB [16] = '{
		k_of(0), k_of(1), k_of(2), k_of(3), k_of(4), k_of(5), k_of(6), k_of(7),
		k_of(8), k_of(9), k_of(10), k_of(11), k_of(12), k_of(13), k_of(14), k_of(15)
	};

endpackage

FILE: rtl/shpe_sincos.sv
// ----------------------------------------------------------------------------
// shpe_sincos
// pipelined sine and cosine: square, constant divides, seven horner steps
// ----------------------------------------------------------------------------
module shpe_sincos (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [30:0]                          x_mag,
	input  logic                                 x_neg,
	input  logic                                 flip,
	output logic signed [shpe_pkg::TRIG_W-1:0]   sin_val,
	output logic signed [shpe_pkg::TRIG_W-1:0]   cos_val
);
	import shpe_pkg::*;

	localparam logic signed [33:0] ONE30 = 34'sd1073741824;

	logic [30:0]        xm_s [2:11];
	logic               xn_s [2:11];
	logic               fl_s [2:11];
	logic [31:0]        q_s2;
	logic [32:0]        n_s3 [14];
	logic [31:0]        ap_s3 [14];
	logic [31:0]        d_s [4:10][14];
	logic signed [33:0] rs_s [5:11];
	logic signed [33:0] rc_s [5:11];
	logic signed [TRIG_W-1:0] sin_s12;
	logic signed [TRIG_W-1:0] cos_s12;

	logic [32:0]        n_c [14];
	logic [31:0]        ap_c [14];
	logic [31:0]        d_c [14];
	logic [33:0]        rem_c [14];
	logic signed [TRIG_W-1:0] sin_c;
	logic signed [TRIG_W-1:0] cos_c;

	// one horner step: 1 - d * r, rounded on the magnitude
	function automatic logic signed [33:0] h_step(
		input logic [31:0] d,
		input logic signed [33:0] r
	);
		logic [33:0] rm;
		logic [33:0] m;
		rm = r[33] ? 34'(-r) : 34'(r);
		m  = 34'(rnd_sh(64'(d) * 64'(rm), 30));
		return ONE30 - (r[33] ? -$signed(m) : $signed(m));
	endfunction

	// divide by constants: reciprocal estimate, then up to two corrections
	always_comb begin
		for (int i = 0; i < 14; i++) begin
			n_c[i]   = {1'b0, q_s2} + 33'(DIVS[i] / 2);
			ap_c[i]  = 32'((64'(n_c[i]) * 64'(RCP[i])) >> 32);
			rem_c[i] = 34'(n_s3[i]) - 34'(ap_s3[i]) * 34'(DIVS[i]);
			d_c[i]   = ap_s3[i] + 32'(rem_c[i] >= 34'(DIVS[i]))
				+ 32'(rem_c[i] >= 34'(2 * DIVS[i]));
		end
	end

	// final products, rounded to q24
	always_comb begin
		logic [33:0] sm;
		logic [33:0] cm;
		logic [TRIG_W-1:0] s24;
		logic [TRIG_W-1:0] c24;
		sm  = rs_s[11][33] ? 34'(-rs_s[11]) : 34'(rs_s[11]);
		cm  = rc_s[11][33] ? 34'(-rc_s[11]) : 34'(rc_s[11]);
		s24 = TRIG_W'(rnd_sh(rnd_sh(64'(xm_s[11]) * 64'(sm), 30), 6));
		c24 = TRIG_W'(rnd_sh(64'(cm), 6));
		sin_c = (xn_s[11] != rs_s[11][33]) ? -$signed(s24) : $signed(s24);
		cos_c = (fl_s[11] != rc_s[11][33]) ? -$signed(c24) : $signed(c24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s[2] <= x_mag;
			xn_s[2] <= x_neg;
			fl_s[2] <= flip;
			for (int j = 3; j <= 11; j++) begin
				xm_s[j] <= xm_s[j-1];
				xn_s[j] <= xn_s[j-1];
				fl_s[j] <= fl_s[j-1];
			end
			q_s2 <= 32'(rnd_sh(64'(x_mag) * 64'(x_mag), 30));
			n_s3 <= n_c;
			ap_s3 <= ap_c;
			d_s[4] <= d_c;
			for (int j = 5; j <= 10; j++)
				d_s[j] <= d_s[j-1];
			rs_s[5] <= h_step(d_s[4][0], ONE30);
			rc_s[5] <= h_step(d_s[4][7], ONE30);
			for (int j = 6; j <= 11; j++) begin
				rs_s[j] <= h_step(d_s[j-1][j-5], rs_s[j-1]);
				rc_s[j] <= h_step(d_s[j-1][j+2], rc_s[j-1]);
			end
			sin_s12 <= sin_c;
			cos_s12 <= cos_c;
		end
	end

	assign sin_val = sin_s12;
	assign cos_val = cos_s12;

endmodule

FILE: rtl/spherical_harmonic_polar_eval.sv
// ----------------------------------------------------------------------------
// spherical_harmonic_polar_eval
// polar part of the real spherical harmonics for degrees 0, 2, 4 and 6
// ----------------------------------------------------------------------------
// usage
//  - input channel in_valid/in_ready carries one item: polar_angle (q2.16
//    radians), degree, order (two's complement) and axial_only
//  - output channel out_valid/out_ready returns one item per input:
//    harmonic_value (signed q1.16, saturated) and unsupported
//  - 21 register stages: an item taken at the input passes through every one
//    of them before out_valid rises for it
//  - throughput is one item per cycle while the output is not stalled; every
//    stage is a register and the whole pipeline advances together
//  - the sine/cosine unit holds stages 2 to 12: a square, the taylor divides,
//    seven horner steps and the final products
//  - when out_ready is low with a result waiting, the pipeline freezes and
//    in_ready drops in the same cycle; nothing is dropped or repeated
//  - reset clears all valid bits; payload registers are left as they are
//  - unsupported degree or order gives value 0 with unsupported set;
//    axial mode with a nonzero order gives value 0 with unsupported clear
// ----------------------------------------------------------------------------
module spherical_harmonic_polar_eval (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [17:0]                         polar_angle,
	input  logic [2:0]                          degree,
	input  logic signed [3:0]                   order,
	input  logic                                axial_only,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [shpe_pkg::VAL_W-1:0]   harmonic_value,
	output logic                                unsupported
);
	import shpe_pkg::*;

	// pipeline advance: a stall only when a finished item is not taken
	logic en;

	logic              vld_s [1:LAT];
	ctl_t              ctl_s [1:LAT];

	// stage 1 angle folding
	logic [30:0]       xm_s1;
	logic              xn_s1;
	logic              fl_s1;

	// power chains, index is the power
	logic signed [TRIG_W-1:0] c_pow [13:17][1:6];
	logic signed [TRIG_W-1:0] s_pow [13:17][1:6];
	logic signed [TRIG_W-1:0] sin_v;
	logic signed [TRIG_W-1:0] cos_v;

	logic signed [TERM_W-1:0] term_s18 [7];
	logic signed [TRIG_W-1:0] sp_s18;
	logic signed [POLY_W-1:0] poly_s19;
	logic signed [TRIG_W-1:0] sp_s19;
	logic signed [T_W-1:0]    t_s20;
	logic signed [VAL_W-1:0]  val_s21;

	// combinational next values
	ctl_t                     ctl_c;
	logic [30:0]              xm_c;
	logic                     xn_c;
	logic                     fl_c;
	logic signed [TERM_W-1:0] term_c [7];
	logic signed [TRIG_W-1:0] sp_c;
	logic signed [POLY_W-1:0] poly_c;
	logic signed [T_W-1:0]    t_c;
	logic signed [VAL_W-1:0]  val_c;

	assign en       = !vld_s[LAT] || out_ready;
	assign in_ready = en;

	// ---- stage 1: decode the degree/order pair and fold the angle ----
	always_comb begin
		logic [3:0]         am;
		logic [31:0]        th;
		logic signed [33:0] xs;
		am = order[3] ? 4'(-order) : 4'(order);
		ctl_c.neg = !order[3] && order[0];
		ctl_c.bad = 1'b0;
		ctl_c.zero = 1'b0;
		if (degree[0]) begin
			ctl_c.bad = 1'b1;
		end else if (axial_only && (order != 4'sd0)) begin
			ctl_c.zero = 1'b1;
		end else if (am > 4'({1'b0, degree})) begin
			ctl_c.bad = 1'b1;
		end
		ctl_c.zero = ctl_c.zero || ctl_c.bad;
		case (degree)
			3'd0:    ctl_c.row = 4'd0;
			3'd2:    ctl_c.row = 4'd1 + am;
			3'd4:    ctl_c.row = 4'd4 + am;
			3'd6:    ctl_c.row = 4'd9 + am;
			default: ctl_c.row = 4'd0;
		endcase

		// above pi/2 the angle folds to pi - theta and cos changes sign
		th   = {polar_angle, 14'd0};
		fl_c = th > HALF_PI30;
		xs   = fl_c ? $signed({2'b00, PI30}) - $signed({2'b00, th})
			: $signed({2'b00, th});
		xn_c = xs[33];
		xm_c = xs[33] ? 31'(-xs) : 31'(xs);
	end

	// ---- stages 2 to 12: sine and cosine ----
	shpe_sincos u_sincos (
		.clk     (clk),
		.en      (en),
		.x_mag   (xm_s1),
		.x_neg   (xn_s1),
		.flip    (fl_s1),
		.sin_val (sin_v),
		.cos_val (cos_v)
	);

	// ---- stages 13 to 17: powers of cos and sin, the first two in stage 13, then one new power per stage ----

	// ---- stage 18: coefficient terms and the selected sin power ----
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			if (i == 0)
				term_c[i] = TERM_W'(POLY[ctl_s[17].row][i]) * TERM_W'(26'sd16777216);
			else
				term_c[i] = TERM_W'(POLY[ctl_s[17].row][i]) * TERM_W'(c_pow[17][i]);
		end
		case (P_EXP[ctl_s[17].row])
			3'd1:    sp_c = s_pow[17][1];
			3'd2:    sp_c = s_pow[17][2];
			3'd3:    sp_c = s_pow[17][3];
			3'd4:    sp_c = s_pow[17][4];
			3'd5:    sp_c = s_pow[17][5];
			3'd6:    sp_c = s_pow[17][6];
			default: sp_c = 26'sd16777216;
		endcase
	end

	// ---- stage 19: polynomial sum ----
	always_comb begin
		poly_c = '0;
		for (int i = 0; i < 7; i++)
			poly_c = poly_c + POLY_W'(term_s18[i]);
	end

	// ---- stage 20: polynomial times sin power ----
	always_comb begin
		logic [POLY_W-1:0] pm;
		logic [TRIG_W-1:0] sm;
		logic [T_W-1:0]    tm;
		pm  = poly_s19[POLY_W-1] ? POLY_W'(-poly_s19) : POLY_W'(poly_s19);
		sm  = sp_s19[TRIG_W-1] ? TRIG_W'(-sp_s19) : TRIG_W'(sp_s19);
		tm  = T_W'(rnd_sh(64'(pm) * 64'(sm), 24));
		t_c = (poly_s19[POLY_W-1] != sp_s19[TRIG_W-1]) ? -$signed(tm) : $signed(tm);
	end

	// ---- stage 21: normalise, sign, round to q16 and saturate, or force zero ----
	always_comb begin
		logic [T_W-1:0]  tm;
		logic [63:0]     ym;
		logic            yneg;
		tm   = t_s20[T_W-1] ? T_W'(-t_s20) : T_W'(t_s20);
		ym   = rnd_sh(rnd_sh(64'(K_TAB[ctl_s[20].row]) * 64'(tm), 24), 8);
		// condon-shortley sign for positive odd orders
		yneg = t_s20[T_W-1] != ctl_s[20].neg;
		if (ctl_s[20].zero)
			val_c = '0;
		else if (yneg && ym > 64'd131072)
			val_c = $signed(VAL_MIN);
		else if (!yneg && ym > 64'd131071)
			val_c = $signed(VAL_MAX);
		else if (yneg)
			val_c = -$signed(VAL_W'(ym));
		else
			val_c = $signed(VAL_W'(ym));
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= LAT; j++)
				vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int j = 2; j <= LAT; j++)
				vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[1] <= ctl_c;
			for (int j = 2; j <= LAT; j++)
				ctl_s[j] <= ctl_s[j-1];
			xm_s1 <= xm_c;
			xn_s1 <= xn_c;
			fl_s1 <= fl_c;
			// first and second powers enter together
			c_pow[13][1] <= cos_v;
			s_pow[13][1] <= sin_v;
			c_pow[13][2] <= mul24(cos_v, cos_v);
			s_pow[13][2] <= mul24(sin_v, sin_v);
			for (int i = 3; i <= 6; i++) begin
				c_pow[13][i] <= '0;
				s_pow[13][i] <= '0;
			end
			for (int j = 14; j <= 17; j++) begin
				for (int i = 1; i <= 6; i++) begin
					if (i == j - 11) begin
						c_pow[j][i] <= mul24(c_pow[j-1][j-12], c_pow[j-1][1]);
						s_pow[j][i] <= mul24(s_pow[j-1][j-12], s_pow[j-1][1]);
					end else begin
						c_pow[j][i] <= c_pow[j-1][i];
						s_pow[j][i] <= s_pow[j-1][i];
					end
				end
			end
			term_s18 <= term_c;
			sp_s18   <= sp_c;
			poly_s19 <= poly_c;
			sp_s19   <= sp_s18;
			t_s20    <= t_c;
			val_s21  <= val_c;
		end
	end

	assign out_valid      = vld_s[LAT];
	assign harmonic_value = val_s21;
	assign unsupported    = ctl_s[LAT].bad;

	// an unsupported pair never carries a value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> harmonic_value == '0)
		else $error("unsupported item with nonzero value");

	// a refused result stops the input side in the same cycle
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// the pipeline only refuses input with a finished item waiting
	a_ready_why: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input refused without a waiting item");

endmodule

FILE: verif/tb_spherical_harmonic_polar_eval.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spherical_harmonic_polar_eval
// self-checking bench for the polar harmonic evaluator: a bursty driver feeds
// angle/degree/order items, a stalling sink drains results, and a bit-exact
// fixed-point predictor checks every value and unsupported flag in order
// ----------------------------------------------------------------------------
module tb_spherical_harmonic_polar_eval;
	import shpe_pkg::*;

	localparam int  N_RANDOM   = 750;
	localparam int  IDLE_LIMIT = 4000;
	localparam int  HOLD_LEN   = 400;
	localparam longint Q30_ONE  = 64'sd1 << 30;
	localparam longint Q30_PI   = 64'sd3373259426;
	localparam longint Q30_HPI  = 64'sd1686629713;
	localparam longint INV_PI48 = 64'sd89596267800354;
	localparam int  ANGLE_PI   = 205887;

	typedef struct {
		logic [17:0]       angle;
		logic [2:0]        deg;
		logic signed [3:0] ord;
		logic              axial;
	} harm_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    bad;
	} harm_res_t;

	// table rows indexed (l/2)^2 + |m|: scale a/b, sin power, sqrt(n/(d pi)), legendre
	localparam int ROW_A [16] = '{1,1,1,1,3,3,3,3,3,1,1,1,1,3,3,1};
	localparam int ROW_B [16] = '{2,4,2,4,16,8,8,8,16,32,16,64,32,32,32,64};
	localparam int ROW_P [16] = '{0,0,1,2,0,1,2,3,4,0,1,2,3,4,5,6};
	localparam int ROW_N [16] = '{1,5,15,15,1,5,5,35,35,13,273,1365,1365,91,1001,3003};
	localparam int ROW_D [16] = '{1,1,2,2,1,1,2,1,2,1,2,1,1,2,1,1};
	localparam int LEG [16][7] = '{
		'{1,0,0,0,0,0,0},   '{-1,0,3,0,0,0,0},  '{0,1,0,0,0,0,0},   '{1,0,0,0,0,0,0},
		'{3,0,-30,0,35,0,0}, '{0,-3,0,7,0,0,0}, '{-1,0,7,0,0,0,0},  '{0,1,0,0,0,0,0},
		'{1,0,0,0,0,0,0},   '{-5,0,105,0,-315,0,231}, '{0,5,0,-30,0,33,0},
		'{1,0,-18,0,33,0,0}, '{0,-3,0,11,0,0,0}, '{-1,0,11,0,0,0,0}, '{0,1,0,0,0,0,0},
		'{1,0,0,0,0,0,0}
	};
	localparam int SIN_K [7] = '{210, 156, 110, 72, 42, 20, 6};
	localparam int COS_K [7] = '{182, 132, 90, 56, 30, 12, 2};

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [17:0]             polar_angle;
	logic [2:0]              degree;
	logic signed [3:0]       order;
	logic                    axial_only;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] harmonic_value;
	logic                    unsupported;

	harm_req_t pending_items[$];
	harm_res_t expected_results[$];
	int        errors;
	int        results_seen;
	int        idle_cycles;
	logic      in_took;
	int        burst_left;
	int        gap_left;
	int        sink_mode;
	int        sink_phase;
	int        hold_left;
	bit        hold_done;

	spherical_harmonic_polar_eval dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.polar_angle    (polar_angle),
		.degree         (degree),
		.order          (order),
		.axial_only     (axial_only),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.harmonic_value (harmonic_value),
		.unsupported    (unsupported)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- fixed-point predictor ----------------

	// magnitude product shifted right, rounding half away from zero
	function automatic longint q_mul(input longint a, input longint b, input int sh);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		m  = (ma * mb + (64'd1 << (sh - 1))) >> sh;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint q_round(input longint v, input int sh);
		logic [63:0] m;
		m = (((v < 0) ? 64'(-v) : 64'(v)) + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// nested taylor series in q30; q is x squared
	function automatic longint taylor_q30(input longint q, input bit cosine);
		longint r;
		longint k;
		r = Q30_ONE;
		for (int i = 0; i < 7; i++) begin
			k = cosine ? COS_K[i] : SIN_K[i];
			r = Q30_ONE - q_mul((q + k / 2) / k, r, 30);
		end
		return r;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] probe;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v    = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic harm_res_t predict_harmonic(input harm_req_t it);
		harm_res_t   res;
		int          ord;
		int          am;
		int          row;
		longint      th;
		longint      x;
		longint      q;
		longint      s24;
		longint      c24;
		longint      cpow;
		longint      spow;
		longint      poly;
		longint      t;
		longint      kq;
		longint      y;
		logic [63:0] root;
		bit          flip;
		res.value = '0;
		res.bad   = 1'b0;
		ord = int'(it.ord);
		am  = (ord < 0) ? -ord : ord;
		if (it.deg[0] || it.deg > 3'd6) begin
			res.bad = 1'b1;
		end else if (it.axial && ord != 0) begin
			res.bad = 1'b0;
		end else if (am > int'(it.deg)) begin
			res.bad = 1'b1;
		end else begin
			row  = (it.deg / 2) * (it.deg / 2) + am;
			th   = longint'(it.angle) << 14;
			flip = th > Q30_HPI;
			x    = flip ? Q30_PI - th : th;
			q    = q_mul(x, x, 30);
			s24  = q_round(q_mul(x, taylor_q30(q, 1'b0), 30), 6);
			c24  = taylor_q30(q, 1'b1);
			if (flip) c24 = -c24;
			c24  = q_round(c24, 6);
			poly = 0;
			cpow = 64'sd1 << 24;
			for (int i = 0; i < 7; i++) begin
				if (i > 0) cpow = q_mul(cpow, c24, 24);
				poly += longint'(LEG[row][i]) * cpow;
			end
			spow = 64'sd1 << 24;
			for (int i = 0; i < ROW_P[row]; i++) spow = q_mul(spow, s24, 24);
			t    = q_mul(poly, spow, 24);
			root = int_sqrt((64'(ROW_N[row]) * 64'(INV_PI48) + 64'(ROW_D[row] / 2))
				/ 64'(ROW_D[row]));
			kq   = longint'((64'(ROW_A[row]) * root + 64'(ROW_B[row] / 2)) / 64'(ROW_B[row]));
			y    = q_round(q_mul(kq, t, 24), 8);
			// condon-shortley sign for positive odd orders
			if (ord > 0 && ord % 2 == 1) y = -y;
			if (y > 131071) y = 131071;
			if (y < -131072) y = -131072;
			res.value = VAL_W'(y);
		end
		return res;
	endfunction

	// ---------------- stimulus ----------------

	function automatic harm_req_t make_item(input int angle, input int deg, input int ord,
		input bit axial);
		harm_req_t it;
		it.angle = 18'(angle);
		it.deg   = 3'(deg);
		it.ord   = 4'(ord);
		it.axial = axial;
		return it;
	endfunction

	initial begin
		harm_req_t it;
		int        d;
		// directed: angle extremes, quarter turn, every degree, order edges, axial cases
		pending_items.push_back(make_item(0, 0, 0, 0));
		pending_items.push_back(make_item(ANGLE_PI, 6, 0, 0));
		pending_items.push_back(make_item(102943, 2, 1, 0));   // just below pi/2
		pending_items.push_back(make_item(102944, 2, -1, 0));  // just above pi/2
		pending_items.push_back(make_item(262143, 6, 6, 0));   // above pi: sin negative
		pending_items.push_back(make_item(262143, 4, -3, 0));
		pending_items.push_back(make_item(51472, 6, 5, 0));
		pending_items.push_back(make_item(51472, 6, -6, 0));
		pending_items.push_back(make_item(154415, 4, 4, 0));
		pending_items.push_back(make_item(70000, 1, 0, 0));    // odd degree
		pending_items.push_back(make_item(70000, 3, 1, 1));    // odd degree in axial mode
		pending_items.push_back(make_item(70000, 7, -1, 0));
		pending_items.push_back(make_item(70000, 5, 0, 1));
		pending_items.push_back(make_item(30000, 6, -8, 0));   // most negative order
		pending_items.push_back(make_item(30000, 6, 7, 0));    // order above degree
		pending_items.push_back(make_item(30000, 2, 3, 0));
		pending_items.push_back(make_item(30000, 0, -1, 0));
		pending_items.push_back(make_item(30000, 4, 2, 1));    // axial, nonzero order
		pending_items.push_back(make_item(30000, 6, -8, 1));
		pending_items.push_back(make_item(30000, 6, 0, 1));    // axial, order zero
		pending_items.push_back(make_item(1, 4, 3, 0));
		pending_items.push_back(make_item(205886, 2, 2, 0));
		// random: mostly supported pairs within [0, pi], some of anything
		repeat (N_RANDOM) begin
			it.angle = ($urandom_range(0, 9) == 0) ? 18'($urandom)
				: 18'($urandom_range(0, ANGLE_PI));
			if ($urandom_range(0, 9) < 8) begin
				d        = 2 * $urandom_range(0, 3);
				it.deg   = 3'(d);
				it.ord   = 4'($urandom_range(0, 2 * d) - d);
			end else begin
				it.deg = 3'($urandom);
				it.ord = 4'($urandom);
			end
			it.axial = ($urandom_range(0, 4) == 0);
			pending_items.push_back(it);
		end
	end

	// reset and end of run
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		do @(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS spherical_harmonic_polar_eval");
		end else begin
			$display("FAIL spherical_harmonic_polar_eval");
		end
		$finish;
	end

	// driver: bursts of items with random gaps, held until accepted
	initial begin
		in_valid    = 1'b0;
		polar_angle = '0;
		degree      = '0;
		order       = '0;
		axial_only  = 1'b0;
		burst_left  = 1;
		gap_left    = 0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				harm_req_t it;
				it = pending_items.pop_front();
				polar_angle <= it.angle;
				degree      <= it.deg;
				order       <= it.ord;
				axial_only  <= it.axial;
				in_valid    <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink: stall pattern is re-picked at random as sink_phase counts up; one long hold-off to fill the pipe
	initial begin
		out_ready  = 1'b0;
		sink_mode  = 0;
		sink_phase = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen >= 150) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			sink_phase <= sink_phase + 1;
			if (sink_phase % 64 == 63) sink_mode <= $urandom_range(0, 3);
			case (sink_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (sink_phase % 8) < 5;
			endcase
		end
	end

	// monitor: predict on input accept, check on output accept
	initial begin
		errors       = 0;
		results_seen = 0;
		in_took      = 1'b0;
	end

	always @(posedge clk) begin
		harm_res_t want;
		in_took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_results.push_back(predict_harmonic(make_item(polar_angle, degree,
				order, axial_only)));
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result value=%0d unsupported=%0b", $realtime,
					harmonic_value, unsupported);
				errors <= errors + 1;
			end else begin
				want = expected_results.pop_front();
				if (harmonic_value !== want.value) begin
					$display("%0t: harmonic_value expected %0d actual %0d", $realtime,
						want.value, harmonic_value);
					errors <= errors + 1;
				end
				if (unsupported !== want.bad) begin
					$display("%0t: unsupported expected %0b actual %0b", $realtime,
						want.bad, unsupported);
					errors <= errors + 1;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL spherical_harmonic_polar_eval");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
